// ===== hdl/rrce_pkg.sv =====
package rrce_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   // event codes on the response channel
   localparam logic [2:0] EV_LOADED  = 3'd0;
   localparam logic [2:0] EV_REJECT  = 3'd1;
   localparam logic [2:0] EV_RAN     = 3'd2;
   localparam logic [2:0] EV_PREEMPT = 3'd3;
   localparam logic [2:0] EV_FINISH  = 3'd4;
   localparam logic [2:0] EV_IDLE    = 3'd5;

   // opcodes
   localparam logic [2:0] OP_NOP       = 3'd0;
   localparam logic [2:0] OP_ADD_AX_BX = 3'd1;
   localparam logic [2:0] OP_INC_AX    = 3'd2;
   localparam logic [2:0] OP_SUB_CX_1  = 3'd3;

   // fixed field widths
   localparam int START_PC_W = 7;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       latch_req;
      logic       emit;
      logic [2:0] emit_ev;
      logic       load_wr;
      logic       app_rd;
      logic       app_wr;
      logic       ring_rd;
      logic       ctx_rd;
      logic       drop;
      logic       op_rd;
      logic       exec;
   } rrce_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       store_full;
      logic       no_ctx;
      logic       ring_empty;
      logic       prog_full;
      logic       ctx_done;
      logic       out_free;
   } rrce_sts_type;

endpackage

// ===== hdl/rrce_ram.sv =====
module rrce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rrce_ctrl.sv =====
module rrce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rrce_pkg::rrce_sts_type sts,
   output rrce_pkg::rrce_cmd_type cmd
);

   import rrce_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_APP_CHK,
      S_T_SLOT,
      S_T_CHK,
      S_T_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.req_type)
               REQ_LOAD: begin
                  if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     if (sts.store_full) begin
                        cmd.emit_ev = EV_REJECT;
                     end else begin
                        cmd.emit_ev = EV_LOADED;
                        cmd.load_wr = 1'b1;
                     end
                     state_in = S_IDLE;
                  end
               end
               REQ_APPEND: begin
                  if (sts.no_ctx) begin
                     if (sts.out_free) begin
                        cmd.emit    = 1'b1;
                        cmd.emit_ev = EV_REJECT;
                        state_in    = S_IDLE;
                     end
                  end else begin
                     cmd.app_rd = 1'b1;
                     state_in   = S_APP_CHK;
                  end
               end
               REQ_TICK: begin
                  if (sts.ring_empty) begin
                     if (sts.out_free) begin
                        cmd.emit    = 1'b1;
                        cmd.emit_ev = EV_IDLE;
                        state_in    = S_IDLE;
                     end
                  end else begin
                     cmd.ring_rd = 1'b1;
                     state_in    = S_T_SLOT;
                  end
               end
               default: begin
                  if (sts.out_free) begin
                     cmd.emit    = 1'b1;
                     cmd.emit_ev = EV_IDLE;
                     state_in    = S_IDLE;
                  end
               end
            endcase
         end
         S_APP_CHK: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.prog_full) begin
                  cmd.emit_ev = EV_REJECT;
               end else begin
                  cmd.emit_ev = EV_LOADED;
                  cmd.app_wr  = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_T_SLOT: begin
            cmd.ctx_rd = 1'b1;
            state_in   = S_T_CHK;
         end
         S_T_CHK: begin
            // finished contexts at the front are dropped, then the ring is checked again
            if (sts.ctx_done) begin
               cmd.drop = 1'b1;
               state_in = S_DECODE;
            end else begin
               cmd.op_rd = 1'b1;
               state_in  = S_T_EXEC;
            end
         end
         S_T_EXEC: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/rrce_dpath.sv =====
module rrce_dpath #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_INSTR = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_type,
   input  logic [15:0]            req_task_id,
   input  logic [6:0]             req_start_pc,
   input  logic [31:0]            req_ax_init,
   input  logic [31:0]            req_bx_init,
   input  logic [31:0]            req_cx_init,
   input  logic [7:0]             req_slice_len,
   input  logic [2:0]             req_op_code,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_event_res,
   output logic [15:0]            rsp_run_id,
   output logic [5:0]             rsp_run_pc,
   output logic [2:0]             rsp_run_op,
   output logic [31:0]            rsp_ax_out,
   output logic [31:0]            rsp_bx_out,
   output logic [31:0]            rsp_cx_out,
   output logic                   rsp_bad_op,
   input  rrce_pkg::rrce_cmd_type cmd,
   output rrce_pkg::rrce_sts_type sts
);

   import rrce_pkg::*;

   localparam int SW  = $clog2(MAX_PROCS);
   localparam int CW  = $clog2(MAX_PROCS + 1);
   localparam int LW  = $clog2(MAX_INSTR + 1);
   localparam int IW  = $clog2(MAX_INSTR);
   localparam int PCW = (LW > START_PC_W) ? LW : START_PC_W;
   localparam int OAW = $clog2(MAX_PROCS * MAX_INSTR);

   typedef struct packed {
      logic [15:0]    id;
      logic [PCW-1:0] pc;
      logic [31:0]    ax;
      logic [31:0]    bx;
      logic [31:0]    cx;
      logic [7:0]     slice;
      logic [LW-1:0]  len;
   } ctx_type;

   localparam int CTXW = $bits(ctx_type);

   // latched request
   logic [1:0]  req_type_ff, req_type_in;
   logic [15:0] task_id_ff, task_id_in;
   logic [6:0]  start_pc_ff, start_pc_in;
   logic [31:0] ax_init_ff, ax_init_in;
   logic [31:0] bx_init_ff, bx_init_in;
   logic [31:0] cx_init_ff, cx_init_in;
   logic [7:0]  slice_ff, slice_in;
   logic [2:0]  op_code_ff, op_code_in;

   // scheduler state
   logic [SW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] loaded_ff, loaded_in;
   logic [7:0]    used_ff, used_in;
   logic [SW-1:0] slot_ff, slot_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_event_ff, rsp_event_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic [5:0]  rsp_pc_ff, rsp_pc_in;
   logic [2:0]  rsp_op_ff, rsp_op_in;
   logic [31:0] rsp_ax_ff, rsp_ax_in;
   logic [31:0] rsp_bx_ff, rsp_bx_in;
   logic [31:0] rsp_cx_ff, rsp_cx_in;
   logic        rsp_bad_ff, rsp_bad_in;

   // memory ports
   logic            ctx_wr_en, ctx_rd_en;
   logic [SW-1:0]   ctx_waddr, ctx_raddr;
   ctx_type         ctx_wdata, ctx_rd;
   logic [CTXW-1:0] ctx_rdata;
   logic            ring_wr_en;
   logic [SW-1:0]   ring_wdata, ring_rdata;
   logic            op_wr_en;
   logic [OAW-1:0]  op_waddr, op_raddr;
   logic [2:0]      op_rdata;

   // helpers
   logic [CW-1:0]  loaded_m1;
   logic [SW-1:0]  newest, new_slot, head_adv, tail_idx;
   logic [CW:0]    tail_sum;
   logic [31:0]    ax_new, cx_new;
   logic [PCW-1:0] pc_new;
   logic [7:0]     used_new, slice_lim, slice_fix;
   logic           finished, preempt;

   assign ctx_rd = ctx_type'(ctx_rdata);

   // ring indexes and slot numbers
   always_comb begin
      loaded_m1 = loaded_ff - CW'(1);
      newest    = loaded_m1[SW-1:0];
      new_slot  = loaded_ff[SW-1:0];
      head_adv  = (head_ff == SW'(MAX_PROCS - 1)) ? '0 : head_ff + SW'(1);
      tail_sum  = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
      if (tail_sum >= (CW + 1)'(MAX_PROCS)) begin
         tail_sum = tail_sum - (CW + 1)'(MAX_PROCS);
      end
      tail_idx  = tail_sum[SW-1:0];
   end

   // one opcode on the front context
   always_comb begin
      ax_new = ctx_rd.ax;
      cx_new = ctx_rd.cx;
      case (op_rdata)
         OP_ADD_AX_BX: ax_new = ctx_rd.ax + ctx_rd.bx;
         OP_INC_AX:    ax_new = ctx_rd.ax + 32'd1;
         OP_SUB_CX_1:  cx_new = ctx_rd.cx - 32'd1;
         default:      ax_new = ctx_rd.ax;
      endcase
      pc_new    = ctx_rd.pc + PCW'(1);
      used_new  = used_ff + 8'd1;
      slice_lim = (ctx_rd.slice == 8'd0) ? 8'd1 : ctx_rd.slice;
      finished  = pc_new >= PCW'(ctx_rd.len);
      preempt   = !finished && (used_new >= slice_lim);
      slice_fix = (slice_ff == 8'd0) ? 8'd1 : slice_ff;
   end

   // context store access
   always_comb begin
      ctx_rd_en = cmd.app_rd | cmd.ctx_rd;
      ctx_raddr = cmd.app_rd ? newest : ring_rdata;
      ctx_wr_en = cmd.load_wr | cmd.app_wr | cmd.exec;
      ctx_waddr = slot_ff;
      ctx_wdata = ctx_rd;
      if (cmd.load_wr) begin
         ctx_waddr       = new_slot;
         ctx_wdata.id    = task_id_ff;
         ctx_wdata.pc    = PCW'(start_pc_ff);
         ctx_wdata.ax    = ax_init_ff;
         ctx_wdata.bx    = bx_init_ff;
         ctx_wdata.cx    = cx_init_ff;
         ctx_wdata.slice = slice_fix;
         ctx_wdata.len   = '0;
      end else if (cmd.app_wr) begin
         ctx_waddr     = newest;
         ctx_wdata.len = ctx_rd.len + LW'(1);
      end else begin
         ctx_wdata.ax = ax_new;
         ctx_wdata.cx = cx_new;
         ctx_wdata.pc = pc_new;
      end
   end

   // ring and program store access
   always_comb begin
      ring_wr_en = cmd.load_wr | (cmd.exec & preempt);
      ring_wdata = cmd.load_wr ? new_slot : slot_ff;
      op_wr_en   = cmd.app_wr;
      op_waddr   = OAW'(newest) * OAW'(MAX_INSTR) + OAW'(ctx_rd.len[IW-1:0]);
      op_raddr   = OAW'(slot_ff) * OAW'(MAX_INSTR) + OAW'(ctx_rd.pc[IW-1:0]);
   end

   // request latch
   always_comb begin
      req_type_in = req_type_ff;
      task_id_in  = task_id_ff;
      start_pc_in = start_pc_ff;
      ax_init_in  = ax_init_ff;
      bx_init_in  = bx_init_ff;
      cx_init_in  = cx_init_ff;
      slice_in    = slice_ff;
      op_code_in  = op_code_ff;
      if (cmd.latch_req) begin
         req_type_in = req_type;
         task_id_in  = req_task_id;
         start_pc_in = req_start_pc;
         ax_init_in  = req_ax_init;
         bx_init_in  = req_bx_init;
         cx_init_in  = req_cx_init;
         slice_in    = req_slice_len;
         op_code_in  = req_op_code;
      end
   end

   // ring pointers, counters and turn usage
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      loaded_in = loaded_ff;
      used_in   = used_ff;
      slot_in   = cmd.ctx_rd ? ring_rdata : slot_ff;
      if (cmd.load_wr) begin
         count_in  = count_ff + CW'(1);
         loaded_in = loaded_ff + CW'(1);
      end
      if (cmd.drop || (cmd.exec && finished)) begin
         head_in  = head_adv;
         count_in = count_ff - CW'(1);
         used_in  = 8'd0;
      end else if (cmd.exec && preempt) begin
         head_in = head_adv;
         used_in = 8'd0;
      end else if (cmd.exec) begin
         used_in = used_new;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_event_in = rsp_event_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_pc_in    = rsp_pc_ff;
      rsp_op_in    = rsp_op_ff;
      rsp_ax_in    = rsp_ax_ff;
      rsp_bx_in    = rsp_bx_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = cmd.emit_ev;
         rsp_id_in    = '0;
         rsp_pc_in    = '0;
         rsp_op_in    = '0;
         rsp_ax_in    = '0;
         rsp_bx_in    = '0;
         rsp_cx_in    = '0;
         rsp_bad_in   = 1'b0;
         if (cmd.exec) begin
            rsp_event_in = finished ? EV_FINISH : (preempt ? EV_PREEMPT : EV_RAN);
            rsp_id_in    = ctx_rd.id;
            rsp_pc_in    = ctx_rd.pc[5:0];
            rsp_op_in    = op_rdata;
            rsp_ax_in    = ax_new;
            rsp_bx_in    = ctx_rd.bx;
            rsp_cx_in    = cx_new;
            rsp_bad_in   = op_rdata[2];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         loaded_ff    <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         loaded_ff    <= loaded_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_type_ff  <= req_type_in;
      task_id_ff   <= task_id_in;
      start_pc_ff  <= start_pc_in;
      ax_init_ff   <= ax_init_in;
      bx_init_ff   <= bx_init_in;
      cx_init_ff   <= cx_init_in;
      slice_ff     <= slice_in;
      op_code_ff   <= op_code_in;
      slot_ff      <= slot_in;
      rsp_event_ff <= rsp_event_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_pc_ff    <= rsp_pc_in;
      rsp_op_ff    <= rsp_op_in;
      rsp_ax_ff    <= rsp_ax_in;
      rsp_bx_ff    <= rsp_bx_in;
      rsp_cx_ff    <= rsp_cx_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // status to the controller
   always_comb begin
      sts.req_type   = req_type_ff;
      sts.store_full = loaded_ff == CW'(MAX_PROCS);
      sts.no_ctx     = loaded_ff == '0;
      sts.ring_empty = count_ff == '0;
      sts.prog_full  = ctx_rd.len >= LW'(MAX_INSTR);
      sts.ctx_done   = ctx_rd.pc >= PCW'(ctx_rd.len);
      sts.out_free   = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_run_id    = rsp_id_ff;
   assign rsp_run_pc    = rsp_pc_ff;
   assign rsp_run_op    = rsp_op_ff;
   assign rsp_ax_out    = rsp_ax_ff;
   assign rsp_bx_out    = rsp_bx_ff;
   assign rsp_cx_out    = rsp_cx_ff;
   assign rsp_bad_op    = rsp_bad_ff;

   // context records
   rrce_ram #(
      .WIDTH(CTXW),
      .DEPTH(MAX_PROCS)
   ) u_ctx_ram (
      .clock  (clock),
      .wr_en  (ctx_wr_en),
      .wr_addr(ctx_waddr),
      .wr_data(ctx_wdata),
      .rd_en  (ctx_rd_en),
      .rd_addr(ctx_raddr),
      .rd_data(ctx_rdata)
   );

   // ready ring of slot numbers
   rrce_ram #(
      .WIDTH(SW),
      .DEPTH(MAX_PROCS)
   ) u_ring_ram (
      .clock  (clock),
      .wr_en  (ring_wr_en),
      .wr_addr(tail_idx),
      .wr_data(ring_wdata),
      .rd_en  (cmd.ring_rd),
      .rd_addr(head_ff),
      .rd_data(ring_rdata)
   );

   // programs, MAX_INSTR opcodes per slot
   rrce_ram #(
      .WIDTH(3),
      .DEPTH(MAX_PROCS * MAX_INSTR)
   ) u_op_ram (
      .clock  (clock),
      .wr_en  (op_wr_en),
      .wr_addr(op_waddr),
      .wr_data(op_code_ff),
      .rd_en  (cmd.op_rd),
      .rd_addr(op_raddr),
      .rd_data(op_rdata)
   );

endmodule

// ===== hdl/round_robin_context_executor_unit.sv =====
// load and idle respond from decode, append from the append check after a context read;
// tick reads ring, context and opcode, first dropping each finished context at the front
// one transaction at a time; the next request is taken the cycle after its response is
// registered, set by the read-then-write passes through the context, ring and program rams
// synchronous active-high reset clears ring head, ring count, load count, slice usage and
// the response valid; the rams are not cleared and need no clearing pass
module round_robin_context_executor_unit #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_INSTR = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_task_id,
   input  logic [6:0]         req_start_pc,
   input  logic signed [31:0] req_ax_init,
   input  logic signed [31:0] req_bx_init,
   input  logic signed [31:0] req_cx_init,
   input  logic [7:0]         req_slice_len,
   input  logic [2:0]         req_op_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_event_res,
   output logic [15:0]        rsp_run_id,
   output logic [5:0]         rsp_run_pc,
   output logic [2:0]         rsp_run_op,
   output logic signed [31:0] rsp_ax_out,
   output logic signed [31:0] rsp_bx_out,
   output logic signed [31:0] rsp_cx_out,
   output logic               rsp_bad_op
);

   import rrce_pkg::*;

   rrce_cmd_type cmd;
   rrce_sts_type sts;

   // sequencer
   rrce_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // context stores, ring and response register
   rrce_dpath #(
      .MAX_PROCS(MAX_PROCS),
      .MAX_INSTR(MAX_INSTR)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_type     (req_type),
      .req_task_id  (req_task_id),
      .req_start_pc (req_start_pc),
      .req_ax_init  (req_ax_init),
      .req_bx_init  (req_bx_init),
      .req_cx_init  (req_cx_init),
      .req_slice_len(req_slice_len),
      .req_op_code  (req_op_code),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_event_res(rsp_event_res),
      .rsp_run_id   (rsp_run_id),
      .rsp_run_pc   (rsp_run_pc),
      .rsp_run_op   (rsp_run_op),
      .rsp_ax_out   (rsp_ax_out),
      .rsp_bx_out   (rsp_bx_out),
      .rsp_cx_out   (rsp_cx_out),
      .rsp_bad_op   (rsp_bad_op),
      .cmd          (cmd),
      .sts          (sts)
   );

   // a new response never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("response register overwritten");

   // a load never writes past the context store
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_wr |-> !sts.store_full)
      else $error("load into full context store");

   // execution only with a context in the ring
   assert property (@(posedge clock) disable iff (reset)
      (cmd.exec || cmd.drop) |-> !sts.ring_empty)
      else $error("ring used while empty");

   // one transaction at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

endmodule
